>>> rtl/rv32x_pkg.sv
// ----------------------------------------------------------------------------
// rv32x_pkg
// Types and constants shared by the RV32IM execute pipeline.
// ----------------------------------------------------------------------------
package rv32x_pkg;

  localparam int DIV_STEPS = 32;

  localparam logic [6:0] OP_LUI    = 7'b0110111;
  localparam logic [6:0] OP_AUIPC  = 7'b0010111;
  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_JALR   = 7'b1100111;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_IMM    = 7'b0010011;
  localparam logic [6:0] OP_REG    = 7'b0110011;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE = 7'd0;
  localparam logic [6:0] F7_ALT  = 7'd32;
  localparam logic [6:0] F7_MUL  = 7'd1;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_UNHAND = 2'd1;
  localparam logic [1:0] ST_SYSTEM = 2'd2;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_LOAD  = 2'd1;
  localparam logic [1:0] MEM_STORE = 2'd2;

  localparam logic [2:0] M_MUL    = 3'd0;
  localparam logic [2:0] M_MULH   = 3'd1;
  localparam logic [2:0] M_MULHSU = 3'd2;
  localparam logic [2:0] M_MULHU  = 3'd3;
  localparam logic [2:0] M_DIV    = 3'd4;
  localparam logic [2:0] M_DIVU   = 3'd5;
  localparam logic [2:0] M_REM    = 3'd6;
  localparam logic [2:0] M_REMU   = 3'd7;

  typedef struct packed {
    logic [31:0] instruction;
    logic [31:0] pc;
    logic [31:0] rs1_value;
    logic [31:0] rs2_value;
  } req_t;

  typedef struct packed {
    logic        rd_write;
    logic [4:0]  rd_index;
    logic [31:0] rd_value;
    logic [31:0] next_pc;
    logic [1:0]  mem_kind;
    logic [31:0] mem_address;
    logic [1:0]  mem_size;
    logic        mem_signed;
    logic [31:0] store_data;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    rsp_t        res;
    logic        is_m;
    logic [2:0]  mfn;
    logic [31:0] a;
    logic [31:0] b;
    logic [63:0] prod;
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] dsr;
    logic        neg_q;
    logic        neg_r;
  } pipe_t;

endpackage

>>> rtl/rv32x_dec.sv
// ----------------------------------------------------------------------------
// rv32x_dec
// Decode and execute the base instructions; flag system and unhandled ones; prepare M operands.
// ----------------------------------------------------------------------------
module rv32x_dec import rv32x_pkg::*; (
  input  req_t  req,
  output pipe_t pipe
);

  logic [31:0] ins, pc, a, b;
  logic [6:0]  op, f7;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [31:0] ii, is, ib, ij, iu;
  logic [31:0] val, npc, addr, sdata;
  logic [1:0]  kind, size, st;
  logic [4:0]  idx;
  logic        sgn, wr, tk, mop, dsg;

  always_comb begin
    ins = req.instruction;
    pc  = req.pc;
    a   = req.rs1_value;
    b   = req.rs2_value;
    op  = ins[6:0];
    rd  = ins[11:7];
    f3  = ins[14:12];
    f7  = ins[31:25];
    ii  = {{20{ins[31]}}, ins[31:20]};
    is  = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    ib  = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    ij  = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    iu  = {ins[31:12], 12'b0};

    val = '0; npc = pc + 32'd4; addr = '0; sdata = '0;
    kind = MEM_NONE; size = 2'd0; sgn = 1'b0; st = ST_DONE;
    idx = rd; wr = 1'b1; tk = 1'b0; mop = 1'b0;

    case (op)
      OP_LUI: val = iu;
      OP_AUIPC: val = pc + iu;
      OP_JAL: begin
        val = pc + 32'd4;
        npc = pc + ij;
      end
      OP_JALR: begin
        if (f3 != 3'd0) begin
          st = ST_UNHAND;
        end else begin
          val = pc + 32'd4;
          npc = (a + ii) & ~32'd1;
        end
      end
      OP_BRANCH: begin
        wr = 1'b0; idx = '0;
        case (f3[2:1])
          2'd0: tk = (a == b);
          2'd2: tk = ($signed(a) < $signed(b));
          2'd3: tk = (a < b);
          default: st = ST_UNHAND;
        endcase
        if (f3[0]) tk = !tk;
        if (tk) npc = pc + ib;
      end
      OP_LOAD: begin
        wr = 1'b0;
        if (f3 == 3'd3 || f3 > 3'd5) begin
          st = ST_UNHAND;
        end else begin
          kind = MEM_LOAD;
          addr = a + ii;
          size = f3[1:0];
          sgn  = (f3 < 3'd2);
        end
      end
      OP_STORE: begin
        wr = 1'b0; idx = '0;
        if (f3 > 3'd2) begin
          st = ST_UNHAND;
        end else begin
          kind  = MEM_STORE;
          addr  = a + is;
          size  = f3[1:0];
          sdata = b;
        end
      end
      OP_IMM: begin
        case (f3)
          3'd0: val = a + ii;
          3'd2: val = {31'd0, $signed(a) < $signed(ii)};
          3'd3: val = {31'd0, a < ii};
          3'd4: val = a ^ ii;
          3'd6: val = a | ii;
          3'd7: val = a & ii;
          3'd1: begin
            if (f7 != F7_BASE) st = ST_UNHAND;
            else val = a << ii[4:0];
          end
          default: begin
            if (f7 == F7_BASE) val = a >> ii[4:0];
            else if (f7 == F7_ALT) val = 32'($signed(a) >>> ii[4:0]);
            else st = ST_UNHAND;
          end
        endcase
      end
      OP_REG: begin
        if (f7 == F7_BASE) begin
          case (f3)
            3'd0: val = a + b;
            3'd1: val = a << b[4:0];
            3'd2: val = {31'd0, $signed(a) < $signed(b)};
            3'd3: val = {31'd0, a < b};
            3'd4: val = a ^ b;
            3'd5: val = a >> b[4:0];
            3'd6: val = a | b;
            default: val = a & b;
          endcase
        end else if (f7 == F7_ALT) begin
          if (f3 == 3'd0) val = a - b;
          else if (f3 == 3'd5) val = 32'($signed(a) >>> b[4:0]);
          else st = ST_UNHAND;
        end else if (f7 == F7_MUL) begin
          mop = 1'b1;
        end else begin
          st = ST_UNHAND;
        end
      end
      OP_SYSTEM: st = (f3 == 3'd4) ? ST_UNHAND : ST_SYSTEM;
      default: st = ST_UNHAND;
    endcase

    if (st != ST_DONE) begin
      wr = 1'b0; idx = '0; val = '0; npc = pc;
      kind = MEM_NONE; addr = '0; size = 2'd0; sgn = 1'b0; sdata = '0;
      mop = 1'b0;
    end else if (wr && rd == 5'd0) begin
      wr = 1'b0; idx = '0; val = '0; mop = 1'b0;
    end else if (!wr) begin
      val = '0;
    end

    dsg = (f3 == M_DIV) || (f3 == M_REM);

    pipe.res.rd_write    = wr;
    pipe.res.rd_index    = idx;
    pipe.res.rd_value    = val;
    pipe.res.next_pc     = npc;
    pipe.res.mem_kind    = kind;
    pipe.res.mem_address = addr;
    pipe.res.mem_size    = size;
    pipe.res.mem_signed  = sgn;
    pipe.res.store_data  = sdata;
    pipe.res.status      = st;
    pipe.is_m  = mop;
    pipe.mfn   = f3;
    pipe.a     = a;
    pipe.b     = b;
    pipe.prod  = '0;
    pipe.rem   = '0;
    pipe.quo   = (dsg && a[31]) ? (32'd0 - a) : a;
    pipe.dsr   = (dsg && b[31]) ? (32'd0 - b) : b;
    pipe.neg_q = dsg && (a[31] ^ b[31]) && (b != 32'd0);
    pipe.neg_r = dsg && a[31];
  end

endmodule

>>> rtl/rv32x_mul.sv
// ----------------------------------------------------------------------------
// rv32x_mul
// Single 33x33 signed multiplier covering all four multiply flavors.
// ----------------------------------------------------------------------------
module rv32x_mul import rv32x_pkg::*; (
  input  pipe_t       pipe,
  output logic [63:0] prod
);

  logic               as, bs;
  logic signed [32:0] ma, mb;
  logic signed [65:0] pr;

  always_comb begin
    as   = (pipe.mfn == M_MULH) || (pipe.mfn == M_MULHSU);
    bs   = (pipe.mfn == M_MULH);
    ma   = $signed({as & pipe.a[31], pipe.a});
    mb   = $signed({bs & pipe.b[31], pipe.b});
    pr   = ma * mb;
    prod = pr[63:0];
  end

endmodule

>>> rtl/rv32x_divstep.sv
// ----------------------------------------------------------------------------
// rv32x_divstep
// One restoring division step: shift in a dividend bit, subtract if it fits.
// ----------------------------------------------------------------------------
module rv32x_divstep import rv32x_pkg::*; (
  input  pipe_t pin,
  output pipe_t pout
);

  logic [32:0] t, diff;
  logic        ge;

  always_comb begin
    t    = {pin.rem, pin.quo[31]};
    diff = t - {1'b0, pin.dsr};
    ge   = (t >= {1'b0, pin.dsr});
    pout = pin;
    pout.rem = ge ? diff[31:0] : t[31:0];
    pout.quo = {pin.quo[30:0], ge};
  end

endmodule

>>> rtl/rv32x_fin.sv
// ----------------------------------------------------------------------------
// rv32x_fin
// Select the M result, apply signs, and form the final response.
// ----------------------------------------------------------------------------
module rv32x_fin import rv32x_pkg::*; (
  input  pipe_t pipe,
  output rsp_t  rsp
);

  logic [31:0] q, r;

  always_comb begin
    q   = pipe.neg_q ? (32'd0 - pipe.quo) : pipe.quo;
    r   = pipe.neg_r ? (32'd0 - pipe.rem) : pipe.rem;
    rsp = pipe.res;
    if (pipe.is_m) begin
      case (pipe.mfn)
        M_MUL: rsp.rd_value = pipe.prod[31:0];
        M_MULH, M_MULHSU, M_MULHU: rsp.rd_value = pipe.prod[63:32];
        M_DIV, M_DIVU: rsp.rd_value = q;
        default: rsp.rd_value = r;
      endcase
    end
  end

endmodule

>>> rtl/rv32im_execute_unit_core.sv
// ----------------------------------------------------------------------------
// rv32im_execute_unit_core
// RV32IM execute pipeline: decode, multiply and a bit-per-stage divider.
// ----------------------------------------------------------------------------
// Every opcode takes the same path: stage registers 0 to 32, then the output register.
// Throughput: one request per cycle while the skid entry is empty; the 32 divider stages set the depth.
// A two-entry output (response register plus skid) lets the pipe keep
// advancing while a response is stalled, until the skid entry is occupied.
// Reset (synchronous, rst high) clears all valid bits; data is not reset.
module rv32im_execute_unit_core import rv32x_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  // Stage 0 holds the decoded request; stage k holds k division steps.
  localparam int NST = DIV_STEPS + 1;

  pipe_t          stg     [NST];
  pipe_t          stg_next[NST];
  logic [NST-1:0] vld;
  logic           adv;

  rsp_t fin_rsp;
  rsp_t skid;
  logic skid_valid;
  logic [63:0] prod;
  pipe_t step1;

  // Advance the whole pipe unless the skid entry is occupied.
  assign adv       = !skid_valid;
  assign req_stall = skid_valid;

  rv32x_dec u_dec (
    .req  (req),
    .pipe (stg_next[0])
  );

  rv32x_mul u_mul (
    .pipe (stg[0]),
    .prod (prod)
  );

  rv32x_divstep u_step0 (
    .pin  (stg[0]),
    .pout (step1)
  );

  // Stage 1 takes the first division step and latches the product.
  always_comb begin
    stg_next[1]      = step1;
    stg_next[1].prod = prod;
  end

  for (genvar k = 2; k < NST; k++) begin : g_div
    rv32x_divstep u_step (
      .pin  (stg[k-1]),
      .pout (stg_next[k])
    );
  end

  rv32x_fin u_fin (
    .pipe (stg[NST-1]),
    .rsp  (fin_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], req_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NST; k++) begin
        stg[k] <= stg_next[k];
      end
    end
  end

  // Output register and skid: drain skid first, else take the pipe tail,
  // else park the tail in skid while the response is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!rsp_stall) begin
        rsp_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (!rsp_valid || !rsp_stall) begin
      rsp_valid <= vld[NST-1];
    end else if (vld[NST-1]) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!rsp_stall) rsp <= skid;
    end else if (!rsp_valid || !rsp_stall) begin
      rsp <= fin_rsp;
    end else begin
      skid <= fin_rsp;
    end
  end

endmodule

>>> rtl/rv32x_chk.sv
// ----------------------------------------------------------------------------
// rv32x_chk
// Port-level checks for the execute pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module rv32x_chk import rv32x_pkg::*; (
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("response dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> $stable(rsp))
    else $error("response changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_DONE |->
      !rsp.rd_write && rsp.mem_kind == MEM_NONE && rsp.rd_value == 32'd0)
    else $error("side effect on unhandled or system request");

  a_no_x0_write: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.rd_write |-> rsp.rd_index != 5'd0)
    else $error("write to x0");

endmodule

bind rv32im_execute_unit_core rv32x_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
